// ----- sv/gpf_pkg.sv -----
`default_nettype none
package gpf_pkg;

	localparam int unsigned NUMBER_BITS_DEF = 20;
	localparam int unsigned PC_BITS         = 4;

	typedef logic [PC_BITS-1:0] pc_t;

	// datapath operations selected by one control word
	typedef enum logic [3:0] {
		OP_NONE,
		OP_P_INIT,
		OP_LOAD_V_P,
		OP_LOAD_V_Q,
		OP_DIV_START,
		OP_D_INC,
		OP_P_NEXT,
		OP_SET_FOUND,
		OP_CLR_FOUND,
		OP_EMIT
	} op_t;

	// jump conditions; a jump not taken falls through to the next step
	typedef enum logic [3:0] {
		CD_NEVER,
		CD_ALWAYS,
		CD_NO_REQ,
		CD_BAD,
		CD_P_OVER,
		CD_SQ_OVER,
		CD_DIV_BUSY,
		CD_REM_ZERO,
		CD_SEL_LARGE,
		CD_OUT_BUSY
	} cond_t;

	typedef struct packed {
		logic  in_rdy;
		op_t   op;
		cond_t cond;
		pc_t   target;
	} ctrl_t;

	typedef struct packed {
		logic in_acc;
		logic bad;
		logic p_over;
		logic sq_over;
		logic div_busy;
		logic rem_zero;
		logic sel_large;
		logic out_busy;
	} status_t;

	localparam pc_t STEP_WAIT      = 4'd0;
	localparam pc_t STEP_CHECK     = 4'd1;
	localparam pc_t STEP_P_LOOP    = 4'd2;
	localparam pc_t STEP_TEST      = 4'd3;
	localparam pc_t STEP_DIV_WAIT  = 4'd4;
	localparam pc_t STEP_CHK_REM   = 4'd5;
	localparam pc_t STEP_NEXT_D    = 4'd6;
	localparam pc_t STEP_PRIME     = 4'd7;
	localparam pc_t STEP_TEST_Q    = 4'd8;
	localparam pc_t STEP_COMPOSITE = 4'd9;
	localparam pc_t STEP_FOUND     = 4'd10;
	localparam pc_t STEP_NOT_FOUND = 4'd11;
	localparam pc_t STEP_EMIT      = 4'd12;
	localparam pc_t STEP_DONE      = 4'd13;

	function automatic ctrl_t rom_word(input pc_t pc);
		ctrl_t w;
		w = '{in_rdy: 1'b0, op: OP_NONE, cond: CD_ALWAYS, target: STEP_WAIT};
		unique case (pc)
			STEP_WAIT:      w = '{1'b1, OP_NONE,      CD_NO_REQ,    STEP_WAIT};
			STEP_CHECK:     w = '{1'b0, OP_P_INIT,    CD_BAD,       STEP_WAIT};
			STEP_P_LOOP:    w = '{1'b0, OP_LOAD_V_P,  CD_P_OVER,    STEP_NOT_FOUND};
			STEP_TEST:      w = '{1'b0, OP_DIV_START, CD_SQ_OVER,   STEP_PRIME};
			STEP_DIV_WAIT:  w = '{1'b0, OP_NONE,      CD_DIV_BUSY,  STEP_DIV_WAIT};
			STEP_CHK_REM:   w = '{1'b0, OP_D_INC,     CD_REM_ZERO,  STEP_COMPOSITE};
			STEP_NEXT_D:    w = '{1'b0, OP_NONE,      CD_ALWAYS,    STEP_TEST};
			STEP_PRIME:     w = '{1'b0, OP_LOAD_V_Q,  CD_SEL_LARGE, STEP_FOUND};
			STEP_TEST_Q:    w = '{1'b0, OP_NONE,      CD_ALWAYS,    STEP_TEST};
			STEP_COMPOSITE: w = '{1'b0, OP_P_NEXT,    CD_ALWAYS,    STEP_P_LOOP};
			STEP_FOUND:     w = '{1'b0, OP_SET_FOUND, CD_ALWAYS,    STEP_EMIT};
			STEP_NOT_FOUND: w = '{1'b0, OP_CLR_FOUND, CD_NEVER,     STEP_WAIT};
			STEP_EMIT:      w = '{1'b0, OP_EMIT,      CD_OUT_BUSY,  STEP_EMIT};
			STEP_DONE:      w = '{1'b0, OP_NONE,      CD_ALWAYS,    STEP_WAIT};
			default:        w = '{1'b0, OP_NONE,      CD_ALWAYS,    STEP_WAIT};
		endcase
		return w;
	endfunction

endpackage
`default_nettype wire

// ----- sv/gpf_channels.sv -----
`default_nettype none
interface gpf_req_if #(
	parameter int unsigned NUMBER_BITS = gpf_pkg::NUMBER_BITS_DEF
);
	logic                   valid;
	logic                   ready;
	logic [NUMBER_BITS-1:0] number;

	modport source (output valid, output number, input ready);
	modport sink (input valid, input number, output ready);
endinterface

interface gpf_res_if #(
	parameter int unsigned NUMBER_BITS = gpf_pkg::NUMBER_BITS_DEF
);
	logic                   valid;
	logic                   ready;
	logic [NUMBER_BITS-1:0] number_echo;
	logic                   found;
	logic [NUMBER_BITS-2:0] small_prime;
	logic [NUMBER_BITS-1:0] large_prime;

	modport source (output valid, output number_echo, output found, output small_prime,
		output large_prime, input ready);
	modport sink (input valid, input number_echo, input found, input small_prime,
		input large_prime, output ready);
endinterface
`default_nettype wire

// ----- sv/gpf_divider.sv -----
`default_nettype none
module gpf_divider #(
	parameter int unsigned W = gpf_pkg::NUMBER_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] dividend,
	input  logic [W-1:0] divisor,
	output logic         busy,
	output logic [W-1:0] remainder
);
	localparam int unsigned CW = $clog2(W + 1);

	logic [W-1:0]  rem_q;
	logic [W-1:0]  dvd_q;
	logic [W-1:0]  dsr_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic [W:0]    trial;
	logic [W:0]    diff;

	// restoring remainder, one dividend bit per cycle
	assign trial = {rem_q, dvd_q[W-1]};
	assign diff  = trial - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CW'(W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvd_q <= dividend;
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= diff[W] ? trial[W-1:0] : diff[W-1:0];
			dvd_q <= dvd_q << 1;
		end
	end

	assign busy      = busy_q;
	assign remainder = rem_q;
endmodule
`default_nettype wire

// ----- sv/gpf_sequencer.sv -----
`default_nettype none
module gpf_sequencer (
	input  logic             clk,
	input  logic             arst_n,
	input  gpf_pkg::status_t status,
	output gpf_pkg::ctrl_t   ctrl
);
	gpf_pkg::pc_t pc_q;
	gpf_pkg::pc_t pc_d;
	logic         take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= gpf_pkg::STEP_WAIT;
		end else begin
			pc_q <= pc_d;
		end
	end

	always_comb begin
		ctrl = gpf_pkg::rom_word(pc_q);
		unique case (ctrl.cond)
			gpf_pkg::CD_NEVER:     take = 1'b0;
			gpf_pkg::CD_ALWAYS:    take = 1'b1;
			gpf_pkg::CD_NO_REQ:    take = !status.in_acc;
			gpf_pkg::CD_BAD:       take = status.bad;
			gpf_pkg::CD_P_OVER:    take = status.p_over;
			gpf_pkg::CD_SQ_OVER:   take = status.sq_over;
			gpf_pkg::CD_DIV_BUSY:  take = status.div_busy;
			gpf_pkg::CD_REM_ZERO:  take = status.rem_zero;
			gpf_pkg::CD_SEL_LARGE: take = status.sel_large;
			gpf_pkg::CD_OUT_BUSY:  take = status.out_busy;
			default:               take = 1'b1;
		endcase
		pc_d = take ? ctrl.target : pc_q + 1'b1;
	end
endmodule
`default_nettype wire

// ----- sv/gpf_datapath.sv -----
`default_nettype none
module gpf_datapath #(
	parameter int unsigned NUMBER_BITS = gpf_pkg::NUMBER_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  gpf_pkg::ctrl_t         ctrl,
	output gpf_pkg::status_t       status,
	input  logic                   in_valid,
	input  logic [NUMBER_BITS-1:0] in_number,
	input  logic                   out_ready,
	output logic                   out_valid,
	output logic [NUMBER_BITS-1:0] out_number_echo,
	output logic                   out_found,
	output logic [NUMBER_BITS-2:0] out_small_prime,
	output logic [NUMBER_BITS-1:0] out_large_prime
);
	localparam int unsigned N = NUMBER_BITS;

	logic         in_acc;
	logic [N-1:0] n_q;
	logic [N-1:0] p_q;
	logic [N-1:0] q_val;
	logic [N-1:0] v_q;
	logic [N-1:0] d_q;
	logic [N:0]   sq_q;
	logic         sel_q;
	logic         res_found_q;
	logic [N-2:0] res_small_q;
	logic [N-1:0] res_large_q;
	logic         out_valid_q;
	logic         out_found_q;
	logic [N-1:0] out_echo_q;
	logic [N-2:0] out_small_q;
	logic [N-1:0] out_large_q;
	logic         slot_free;
	logic         div_busy;
	logic [N-1:0] rem;

	assign in_acc    = in_valid && ctrl.in_rdy;
	assign q_val     = n_q - p_q;
	assign slot_free = !out_valid_q || out_ready;

	gpf_divider #(
		.W (N)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (ctrl.op == gpf_pkg::OP_DIV_START),
		.dividend  (v_q),
		.divisor   (d_q),
		.busy      (div_busy),
		.remainder (rem)
	);

	always_ff @(posedge clk) begin
		if (in_acc) begin
			n_q <= in_number;
		end
		unique case (ctrl.op)
			gpf_pkg::OP_P_INIT: begin
				p_q <= N'(3);
			end
			gpf_pkg::OP_LOAD_V_P: begin
				v_q   <= p_q;
				d_q   <= N'(2);
				sq_q  <= (N + 1)'(4);
				sel_q <= 1'b0;
			end
			gpf_pkg::OP_LOAD_V_Q: begin
				v_q   <= q_val;
				d_q   <= N'(2);
				sq_q  <= (N + 1)'(4);
				sel_q <= 1'b1;
			end
			gpf_pkg::OP_D_INC: begin
				// (d+1)^2 = d^2 + 2d + 1
				sq_q <= sq_q + {d_q, 1'b1};
				d_q  <= d_q + 1'b1;
			end
			gpf_pkg::OP_P_NEXT: begin
				p_q <= p_q + N'(2);
			end
			gpf_pkg::OP_SET_FOUND: begin
				res_found_q <= 1'b1;
				res_small_q <= p_q[N-2:0];
				res_large_q <= q_val;
			end
			gpf_pkg::OP_CLR_FOUND: begin
				res_found_q <= 1'b0;
				res_small_q <= '0;
				res_large_q <= '0;
			end
			gpf_pkg::OP_EMIT: begin
				if (slot_free) begin
					out_echo_q  <= n_q;
					out_found_q <= res_found_q;
					out_small_q <= res_small_q;
					out_large_q <= res_large_q;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.op == gpf_pkg::OP_EMIT && slot_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		status.in_acc    = in_acc;
		status.bad       = (n_q <= N'(4)) || n_q[0];
		status.p_over    = p_q > (n_q >> 1);
		status.sq_over   = sq_q > {1'b0, v_q};
		status.div_busy  = div_busy;
		status.rem_zero  = rem == '0;
		status.sel_large = sel_q;
		status.out_busy  = !slot_free;
	end

	assign out_valid       = out_valid_q;
	assign out_number_echo = out_echo_q;
	assign out_found       = out_found_q;
	assign out_small_prime = out_small_q;
	assign out_large_prime = out_large_q;
endmodule
`default_nettype wire

// ----- sv/goldbach_partition_finder.sv -----
`default_nettype none
// Splits an even number above four into two odd primes p + q with p <= q, reporting the
// pair with the smallest p (found = 1), or found = 0 with both primes zero when no pair
// exists; odd numbers and numbers of four or less give no result. A small microprogram
// steps odd p upward and tests p and then number - p by trial division with an iterative
// remainder unit that retires one dividend bit per cycle, so an item's run time grows
// with the total count of divisors tried over all candidates. Numbers are taken one at
// a time; the result sits in an output register, so the next number is accepted while
// the previous result waits.
module goldbach_partition_finder #(
	parameter int unsigned NUMBER_BITS = gpf_pkg::NUMBER_BITS_DEF
) (
	input logic       clk,
	input logic       arst_n,
	gpf_req_if.sink   req,
	gpf_res_if.source res
);
	gpf_pkg::ctrl_t   ctrl;
	gpf_pkg::status_t status;

	gpf_sequencer u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.ctrl   (ctrl)
	);

	gpf_datapath #(
		.NUMBER_BITS (NUMBER_BITS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.ctrl            (ctrl),
		.status          (status),
		.in_valid        (req.valid),
		.in_number       (req.number),
		.out_ready       (res.ready),
		.out_valid       (res.valid),
		.out_number_echo (res.number_echo),
		.out_found       (res.found),
		.out_small_prime (res.small_prime),
		.out_large_prime (res.large_prime)
	);

	assign req.ready = ctrl.in_rdy;
endmodule
`default_nettype wire

// ----- sv/gpf_checker.sv -----
`default_nettype none
module gpf_checker #(
	parameter int unsigned NUMBER_BITS = gpf_pkg::NUMBER_BITS_DEF
) (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   res_valid,
	input logic                   res_ready,
	input logic [NUMBER_BITS-1:0] res_number_echo,
	input logic                   res_found,
	input logic [NUMBER_BITS-2:0] res_small_prime,
	input logic [NUMBER_BITS-1:0] res_large_prime
);
	// a stalled result holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_number_echo)
			&& $stable(res_found) && $stable(res_small_prime) && $stable(res_large_prime))
		else $error("stalled result changed");

	// a found pair sums to the number, small part first
	a_pair_sum: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_found |->
			({1'b0, res_small_prime} + res_large_prime) == res_number_echo
			&& {1'b0, res_small_prime} <= res_large_prime)
		else $error("reported pair does not add up");

	// no pair means both primes read zero
	a_no_pair: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_found |-> res_small_prime == '0 && res_large_prime == '0)
		else $error("empty result with nonzero primes");

	// only even numbers above four produce a result
	a_even_only: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !res_number_echo[0] && res_number_echo > NUMBER_BITS'(4))
		else $error("result for an odd or small number");

	// primes of a found pair are odd and at least three
	a_odd_primes: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_found |-> res_small_prime[0] && res_large_prime[0]
			&& res_small_prime >= (NUMBER_BITS - 1)'(3))
		else $error("pair member not an odd prime candidate");
endmodule

bind goldbach_partition_finder gpf_checker #(
	.NUMBER_BITS (NUMBER_BITS)
) u_gpf_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.res_valid       (res.valid),
	.res_ready       (res.ready),
	.res_number_echo (res.number_echo),
	.res_found       (res.found),
	.res_small_prime (res.small_prime),
	.res_large_prime (res.large_prime)
);
`default_nettype wire
